// ===== design/mcpol_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpol_pkg
// Shared types and constants for the multi-channel pwm output latch unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcpol_pkg;

  // default configuration
  localparam int NUM_CHANNELS_DEF     = 6;
  localparam int TICKS_PER_SECOND_DEF = 1000000;

  // timing limits
  localparam int MIN_FREQ = 10;
  localparam int MAX_DUTY = 100;

  // beat field widths
  localparam int FUNC_W    = 3;
  localparam int CHAN_W    = 3;
  localparam int FREQ_W    = 20;
  localparam int DUTY_W    = 8;
  localparam int DUTY_C_W  = 7;
  localparam int BIT_IDX_W = 4;
  localparam int LATCH_W   = 16;

  typedef enum logic [FUNC_W-1:0] {
    F_TICK,
    F_START,
    F_STOP,
    F_STOP_ALL,
    F_WRITE_BIT,
    F_CLEAR
  } func_t;

endpackage

`default_nettype wire

// ===== design/mcpol_if.sv =====
// ----------------------------------------------------------------------------
// mcpol_if
// Command and result channels of the pwm output latch unit (valid/ready).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mcpol_cmd_if import mcpol_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [CHAN_W-1:0]    channel;
  logic [FREQ_W-1:0]    freq_hz;
  logic [DUTY_W-1:0]    duty_pct;
  logic [BIT_IDX_W-1:0] bit_sel;
  logic                 bit_value;

  modport source (output valid, func, channel, freq_hz, duty_pct, bit_sel,
                  bit_value, input ready);
  modport sink   (input valid, func, channel, freq_hz, duty_pct, bit_sel,
                  bit_value, output ready);
endinterface

interface mcpol_res_if import mcpol_pkg::*; #(
  parameter int NCH = NUM_CHANNELS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [LATCH_W-1:0] latch_word;
  logic [NCH-1:0]     running_mask;

  modport source (output valid, latch_word, running_mask, input ready);
  modport sink   (input valid, latch_word, running_mask, output ready);
endinterface

`default_nettype wire

// ===== design/mcpol_ram.sv =====
// ----------------------------------------------------------------------------
// mcpol_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/multi_channel_pwm_output_latch_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pwm_output_latch_unit
// Sixteen-bit output latch with pwm channels on its low bits, timed in ticks.
//
//   port  dir  beat contents
//   cmd   in   func, channel, freq_hz, duty_pct, bit_sel, bit_value
//   res   out  latch_word, running_mask (one beat per cmd beat)
//
// One command at a time. A tick walks the channel memories, reading and then
// writing each channel in turn. A start on a valid channel runs the
// one-bit-per-cycle divider for the period, then scales period times duty by a
// reciprocal of 100. Every other command goes straight to the finish state.
// Reset clears the latch and the running mask; channel memories need no
// clearing since a channel is written when it starts. A stalled result holds
// in the output register while the next command is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_pwm_output_latch_unit import mcpol_pkg::*; #(
  parameter int NUM_CHANNELS     = NUM_CHANNELS_DEF,
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input wire logic clk,
  input wire logic rst,
  mcpol_cmd_if.sink   cmd,
  mcpol_res_if.source res
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(TICKS_PER_SECOND / MIN_FREQ + 1);
  localparam int DIV_W = $clog2(TICKS_PER_SECOND / MIN_FREQ * MAX_DUTY + 1);
  localparam int DCW   = $clog2(DIV_W + 1);

  // ceil(2^RECIP_SH / 100), exact for every product below 2^DIV_W
  localparam int RECIP_SH = DIV_W + 7;
  localparam int RECIP_W  = RECIP_SH - 6;
  localparam int SC_W     = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(MAX_DUTY) - 64'd1) / 64'(MAX_DUTY));

  typedef struct packed {
    logic             in_high;
    logic [CNT_W-1:0] remaining;
    logic [CNT_W-1:0] taken_low;
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] high_len;
    logic [CNT_W-1:0] low_len;
  } timing_t;

  typedef struct packed {
    phase_t ph;
    logic   bit_set;
    logic   bit_clr;
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_WR,
    S_DIV1,
    S_MUL,
    S_SCALE,
    S_CALC,
    S_START_WR,
    S_FINISH
  } state_t;

  function automatic step_t begin_period(input logic [CNT_W-1:0] h,
                                         input logic [CNT_W-1:0] l);
    step_t s;
    s.ph.taken_low = l;
    s.bit_set      = 1'b0;
    s.bit_clr      = 1'b0;
    if (h != '0) begin
      s.ph.in_high   = 1'b1;
      s.ph.remaining = h;
      s.bit_set      = 1'b1;
    end else if (l != '0) begin
      s.ph.in_high   = 1'b0;
      s.ph.remaining = l;
      s.bit_clr      = 1'b1;
    end else begin
      s.ph.in_high   = 1'b0;
      s.ph.remaining = '0;
    end
    return s;
  endfunction

  state_t                state;
  func_t                 op_func;
  logic [IDX_W-1:0]      op_idx;
  logic [IDX_W-1:0]      tick_idx;
  logic [LATCH_W-1:0]    latch;
  logic [NUM_CHANNELS-1:0] running;
  logic                  out_valid;
  logic [LATCH_W-1:0]    out_latch;
  logic [NUM_CHANNELS-1:0] out_mask;

  // restoring divider for the period
  logic [DIV_W-1:0]      dq;
  logic [FREQ_W-1:0]     rem;
  logic [FREQ_W-1:0]     dvs;
  logic [DCW-1:0]        div_cnt;
  logic [FREQ_W:0]       rem_sh;
  logic                  div_ge;
  logic [FREQ_W:0]       rem_sub;

  logic [DUTY_C_W-1:0]   duty_r;
  logic [CNT_W-1:0]      period_r;
  logic [CNT_W-1:0]      h_len;
  logic [CNT_W-1:0]      l_len;
  logic [CNT_W-1:0]      hq;
  logic [CNT_W-1:0]      lq;
  logic [CNT_W+DUTY_C_W-1:0] prod;
  logic [SC_W-1:0]       scaled;

  logic                  ch_ok;
  logic [IDX_W-1:0]      ch_idx;
  logic [FREQ_W-1:0]     freq_c;
  logic [DUTY_C_W-1:0]   duty_c;

  // channel memories
  logic                  tm_wr_en;
  timing_t               tm_wr_data;
  timing_t               tm_rd_data;
  logic                  ph_wr_en;
  logic [IDX_W-1:0]      ph_wr_addr;
  phase_t                ph_wr_data;
  phase_t                ph_rd_data;
  logic                  rd_en;

  step_t                 tk;
  step_t                 st;
  logic [CNT_W-1:0]      rem_dec;
  logic                  tick_last;

  mcpol_ram #(.WIDTH($bits(timing_t)), .DEPTH(NUM_CHANNELS)) u_timing_ram (
    .clk     (clk),
    .wr_en   (tm_wr_en),
    .wr_addr (op_idx),
    .wr_data (tm_wr_data),
    .rd_en   (rd_en),
    .rd_addr (tick_idx),
    .rd_data (tm_rd_data)
  );

  mcpol_ram #(.WIDTH($bits(phase_t)), .DEPTH(NUM_CHANNELS)) u_phase_ram (
    .clk     (clk),
    .wr_en   (ph_wr_en),
    .wr_addr (ph_wr_addr),
    .wr_data (ph_wr_data),
    .rd_en   (rd_en),
    .rd_addr (tick_idx),
    .rd_data (ph_rd_data)
  );

  assign cmd.ready        = (state == S_IDLE) && !rst;
  assign res.valid        = out_valid;
  assign res.latch_word   = out_latch;
  assign res.running_mask = out_mask;

  assign ch_ok  = (cmd.channel != '0) && (32'(cmd.channel) <= NUM_CHANNELS);
  assign ch_idx = IDX_W'(cmd.channel - CHAN_W'(1));
  assign freq_c = (cmd.freq_hz < FREQ_W'(MIN_FREQ)) ? FREQ_W'(MIN_FREQ) : cmd.freq_hz;
  assign duty_c = (cmd.duty_pct > DUTY_W'(MAX_DUTY)) ? DUTY_C_W'(MAX_DUTY)
                                                      : cmd.duty_pct[DUTY_C_W-1:0];

  assign rem_sh  = {rem, dq[DIV_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign prod    = CNT_W'(dq) * duty_r;
  assign scaled  = SC_W'(dq) * SC_W'(RECIP);

  assign tick_last = (tick_idx == IDX_W'(NUM_CHANNELS - 1));

  // high and low lengths from the scaled product
  always_comb begin
    hq = CNT_W'(dq);
    lq = period_r - hq;
    if (duty_r != '0 && hq == '0) begin
      hq = CNT_W'(1);
    end
    if (duty_r != DUTY_C_W'(MAX_DUTY) && lq == '0) begin
      lq = CNT_W'(1);
    end
  end

  // one tick for the channel just read
  always_comb begin
    tk      = begin_period(tm_rd_data.high_len, tm_rd_data.low_len);
    rem_dec = ph_rd_data.remaining - CNT_W'(1);
    if (ph_rd_data.remaining != '0) begin
      if (rem_dec != '0) begin
        tk.ph           = ph_rd_data;
        tk.ph.remaining = rem_dec;
        tk.bit_set      = 1'b0;
        tk.bit_clr      = 1'b0;
      end else if (ph_rd_data.in_high && ph_rd_data.taken_low != '0) begin
        tk.ph.in_high   = 1'b0;
        tk.ph.remaining = ph_rd_data.taken_low;
        tk.ph.taken_low = ph_rd_data.taken_low;
        tk.bit_set      = 1'b0;
        tk.bit_clr      = 1'b1;
      end
    end
  end

  assign st = begin_period(h_len, l_len);

  always_comb begin
    rd_en      = (state == S_TICK_RD);
    tm_wr_en   = (state == S_START_WR);
    tm_wr_data = '{high_len: h_len, low_len: l_len};
    if (state == S_START_WR) begin
      ph_wr_en   = !running[op_idx];
      ph_wr_addr = op_idx;
      ph_wr_data = st.ph;
    end else begin
      ph_wr_en   = (state == S_TICK_WR) && running[tick_idx];
      ph_wr_addr = tick_idx;
      ph_wr_data = tk.ph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      latch     <= '0;
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_func <= func_t'(cmd.func);
            op_idx  <= ch_idx;
            if (func_t'(cmd.func) == F_TICK) begin
              state <= S_TICK_RD;
            end else if (func_t'(cmd.func) == F_START && ch_ok) begin
              state <= S_DIV1;
            end else begin
              state <= S_FINISH;
            end
            case (func_t'(cmd.func))
              F_TICK: begin
                tick_idx <= '0;
              end
              F_START: begin
                if (ch_ok) begin
                  dq      <= DIV_W'(TICKS_PER_SECOND);
                  rem     <= '0;
                  dvs     <= freq_c;
                  div_cnt <= '0;
                  duty_r  <= duty_c;
                end
              end
              F_STOP: begin
                if (ch_ok && running[ch_idx]) begin
                  running[ch_idx] <= 1'b0;
                  latch[ch_idx]   <= 1'b0;
                end
              end
              F_STOP_ALL: begin
                latch[NUM_CHANNELS-1:0] <= latch[NUM_CHANNELS-1:0] & ~running;
                running <= '0;
              end
              F_WRITE_BIT: begin
                latch[cmd.bit_sel] <= cmd.bit_value;
              end
              F_CLEAR: begin
                latch <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_TICK_RD: begin
          state <= S_TICK_WR;
        end
        S_TICK_WR: begin
          if (running[tick_idx]) begin
            if (tk.bit_set) begin
              latch[tick_idx] <= 1'b1;
            end else if (tk.bit_clr) begin
              latch[tick_idx] <= 1'b0;
            end
          end
          if (tick_last) begin
            state <= S_FINISH;
          end else begin
            tick_idx <= tick_idx + IDX_W'(1);
            state    <= S_TICK_RD;
          end
        end
        S_DIV1: begin
          rem     <= div_ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
          dq      <= {dq[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DIV_W - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          period_r <= CNT_W'(dq);
          dq       <= DIV_W'(prod);
          state    <= S_SCALE;
        end
        S_SCALE: begin
          // product over 100 by reciprocal multiply
          dq    <= DIV_W'(scaled >> RECIP_SH);
          state <= S_CALC;
        end
        S_CALC: begin
          h_len <= hq;
          l_len <= lq;
          state <= S_START_WR;
        end
        S_START_WR: begin
          if (!running[op_idx]) begin
            running[op_idx] <= 1'b1;
            if (st.bit_set) begin
              latch[op_idx] <= 1'b1;
            end else if (st.bit_clr) begin
              latch[op_idx] <= 1'b0;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_latch <= latch;
            out_mask  <= running;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_START_WR) |=> running[op_idx])
    else $error("started channel not running");

  a_stop_all_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op_func == F_STOP_ALL) |-> (running == '0))
    else $error("channel still running after stop all");
`endif

endmodule

`default_nettype wire
